>>> hw/rtl/ohi_pkg.sv
// Package for the orbit Hermite interpolator: transfer payload types,
// arithmetic unit request type, sequencer state encodings and constants.
// No dependencies.
package ohi_pkg;

    // Fixed-point 1.0 in Q32.32.
    localparam logic signed [63:0] ONE_Q = 64'sh0000_0001_0000_0000;

    // Item function codes.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Result status codes.
    localparam logic STATUS_OK         = 1'b0;
    localparam logic STATUS_COINCIDENT = 1'b1;

    typedef struct packed {
        logic               func;
        logic [1:0]         slot;
        logic signed [63:0] sample_time;
        logic signed [63:0] pos_x;
        logic signed [63:0] pos_y;
        logic signed [63:0] pos_z;
        logic signed [63:0] vel_x;
        logic signed [63:0] vel_y;
        logic signed [63:0] vel_z;
        logic signed [63:0] query_time;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] out_pos_x;
        logic signed [63:0] out_pos_y;
        logic signed [63:0] out_pos_z;
        logic signed [63:0] out_vel_x;
        logic signed [63:0] out_vel_y;
        logic signed [63:0] out_vel_z;
        logic               status;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef enum logic [2:0] {
        ALU_IDLE,
        ALU_MUL,
        ALU_FIX,
        ALU_DSET,
        ALU_DIV,
        ALU_DFIN,
        ALU_DONE
    } alu_state_t;

    typedef enum logic [5:0] {
        C_IDLE,
        C_CTI,
        C_CHK,
        C_DT,
        C_ROW,
        C_D,
        C_R,
        C_Q,
        C_S,
        C_M,
        C_M2,
        C_F0,
        C_H,
        C_PI,
        C_P,
        C_PR,
        C_HD,
        C_N,
        C_N2,
        C_G1,
        C_E1,
        C_E2,
        C_E,
        C_G0,
        C_A1,
        C_A2,
        C_A,
        C_T1,
        C_T2,
        C_PS,
        C_B1,
        C_B2,
        C_B,
        C_T3,
        C_VS,
        C_OUT
    } ctl_state_t;

endpackage

>>> hw/rtl/ohi_alu.sv
// Shared multi-cycle fixed-point arithmetic unit: saturating add and subtract,
// Q32.32 multiply from 32x32 partial products, and a restoring divider.
// Depends on ohi_pkg.
module ohi_alu
    import ohi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  alu_req_t           req,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic               done,
    output logic signed [63:0] y
);

    localparam logic signed [63:0] MAX_S = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] MIN_S = 64'sh8000_0000_0000_0000;

    alu_state_t          state_reg;
    alu_state_t          state_next;
    logic signed [63:0]  a_reg;
    logic signed [63:0]  b_reg;
    logic [127:0]        acc_reg;
    logic [5:0]          cnt_reg;
    logic [63:0]         rem_reg;
    logic [63:0]         lo_reg;
    logic [63:0]         quo_reg;
    logic [63:0]         ud_reg;
    logic                neg_reg;
    logic signed [63:0]  y_reg;

    // Saturating add and subtract on the request operands.
    logic signed [63:0] sum_w;
    logic signed [63:0] dif_w;
    logic signed [63:0] add_sat;
    logic signed [63:0] sub_sat;

    always_comb
    begin
        sum_w = a + b;
        dif_w = a - b;
        if (a[63] == b[63] && sum_w[63] != a[63])
            add_sat = a[63] ? MIN_S : MAX_S;
        else
            add_sat = sum_w;
        if (a[63] != b[63] && dif_w[63] != a[63])
            sub_sat = a[63] ? MIN_S : MAX_S;
        else
            sub_sat = dif_w;
    end

    // One 32x32 partial product per cycle of the multiply.
    logic [31:0]  pa;
    logic [31:0]  pb;
    logic [63:0]  pp;
    logic [127:0] pp_sh;

    always_comb
    begin
        pa = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        pb = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp = pa * pb;
        case (cnt_reg[1:0])
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    // Signed correction of the high half and saturation of the product.
    logic [63:0]        hi_fix;
    logic signed [63:0] mul_res;

    always_comb
    begin
        hi_fix = acc_reg[127:64] - (a_reg[63] ? b_reg : 64'd0)
                 - (b_reg[63] ? a_reg : 64'd0);
        if (hi_fix[63:31] == '0 || hi_fix[63:31] == '1)
            mul_res = {hi_fix[31:0], acc_reg[63:32]};
        else
            mul_res = hi_fix[63] ? MIN_S : MAX_S;
    end

    // Divider setup and one restoring step.
    logic [63:0] ua_w;
    logic [63:0] ud_w;
    logic        carry_w;
    logic [63:0] rem_sh;
    logic        take_w;

    always_comb
    begin
        ua_w    = a_reg[63] ? 64'd0 - a_reg : a_reg;
        ud_w    = b_reg[63] ? 64'd0 - b_reg : b_reg;
        carry_w = rem_reg[63];
        rem_sh  = {rem_reg[62:0], lo_reg[63]};
        take_w  = carry_w || (rem_sh >= ud_reg);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ALU_IDLE:
            begin
                if (req.start)
                begin
                    case (req.op)
                        OP_MUL:  state_next = ALU_MUL;
                        OP_DIV:  state_next = ALU_DSET;
                        default: state_next = ALU_DONE;
                    endcase
                end
            end
            ALU_MUL:  state_next = (cnt_reg[1:0] == 2'd3) ? ALU_FIX : ALU_MUL;
            ALU_FIX:  state_next = ALU_DONE;
            ALU_DSET:
            begin
                if (ud_w == 64'd0 || {32'd0, ua_w[63:32]} >= ud_w)
                    state_next = ALU_DONE;
                else
                    state_next = ALU_DIV;
            end
            ALU_DIV:  state_next = (cnt_reg == 6'd0) ? ALU_DFIN : ALU_DIV;
            ALU_DFIN: state_next = ALU_DONE;
            ALU_DONE: state_next = ALU_IDLE;
            default:  state_next = ALU_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        done = (state_reg == ALU_DONE);
        y    = y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ALU_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ALU_IDLE:
            begin
                a_reg   <= a;
                b_reg   <= b;
                acc_reg <= '0;
                cnt_reg <= '0;
                if (req.op == OP_ADD)
                    y_reg <= add_sat;
                else
                    y_reg <= sub_sat;
            end
            ALU_MUL:
            begin
                acc_reg <= acc_reg + pp_sh;
                cnt_reg <= cnt_reg + 6'd1;
            end
            ALU_FIX:
            begin
                y_reg <= mul_res;
            end
            ALU_DSET:
            begin
                neg_reg <= a_reg[63] != b_reg[63];
                ud_reg  <= ud_w;
                rem_reg <= {32'd0, ua_w[63:32]};
                lo_reg  <= {ua_w[31:0], 32'd0};
                quo_reg <= '0;
                cnt_reg <= 6'd63;
                if (ud_w == 64'd0)
                    y_reg <= '0;
                else
                    y_reg <= (a_reg[63] != b_reg[63]) ? MIN_S : MAX_S;
            end
            ALU_DIV:
            begin
                rem_reg <= take_w ? rem_sh - ud_reg : rem_sh;
                quo_reg <= {quo_reg[62:0], take_w};
                lo_reg  <= {lo_reg[62:0], 1'b0};
                cnt_reg <= cnt_reg - 6'd1;
            end
            ALU_DFIN:
            begin
                if (neg_reg)
                    y_reg <= (quo_reg > 64'h8000_0000_0000_0000) ? MIN_S : 64'd0 - quo_reg;
                else
                    y_reg <= quo_reg[63] ? MAX_S : quo_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> hw/rtl/orbit_hermite_interpolator.sv
// Top level of the orbit Hermite interpolator: sample store, query sequencer
// and working registers around the shared arithmetic unit.
// Depends on ohi_pkg and ohi_alu.
//
// A load transfer stores one sample and returns nothing. A query transfer runs
// a sequencer that issues every add, multiply and divide through one shared
// arithmetic unit. A divide runs up to 64 restoring steps. For N points, a
// query needs 2*N*(N-1) divides, and the block accepts nothing until the result
// has been transferred. Coincident sample times are caught in a check pass
// before any arithmetic and return status 1 with zero vectors. Reading a slot
// that was never loaded gives undefined results.
module orbit_hermite_interpolator
    import ohi_pkg::*;
#(
    parameter int NUM_POINTS = 4,
    parameter int NUM_AXES   = 3
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    localparam int IW = $clog2(NUM_POINTS);
    localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam logic [IW-1:0] LAST_PT = IW'(NUM_POINTS - 1);
    localparam logic [AW-1:0] LAST_AX = AW'(NUM_AXES - 1);
    localparam logic [IW-1:0] IDX_ONE = IW'(1);
    localparam logic [AW-1:0] AX_ONE  = AW'(1);

    // Sample store.
    logic signed [63:0] times_mem [NUM_POINTS];
    logic signed [63:0] pos_mem   [NUM_POINTS][NUM_AXES];
    logic signed [63:0] vel_mem   [NUM_POINTS][NUM_AXES];

    // Working registers.
    ctl_state_t         state_reg;
    ctl_state_t         state_next;
    logic               busy_reg;
    logic               coin_reg;
    logic [IW-1:0]      i_reg;
    logic [IW-1:0]      j_reg;
    logic [IW-1:0]      k_reg;
    logic [AW-1:0]      ax_reg;
    logic signed [63:0] tq_reg;
    logic signed [63:0] ti_reg;
    logic signed [63:0] d_reg;
    logic signed [63:0] s_reg;
    logic signed [63:0] m_reg;
    logic signed [63:0] t2_reg;
    logic signed [63:0] f0_reg;
    logic signed [63:0] h_reg;
    logic signed [63:0] p_reg;
    logic signed [63:0] hd_reg;
    logic signed [63:0] g1_reg;
    logic signed [63:0] g0_reg;
    logic signed [63:0] dt_reg [NUM_POINTS];
    logic signed [63:0] r_reg  [NUM_POINTS];
    logic signed [63:0] q_reg  [NUM_POINTS];
    logic signed [63:0] ps_reg [NUM_AXES];
    logic signed [63:0] vs_reg [NUM_AXES];

    // Arithmetic unit hookup.
    alu_req_t           alu_req;
    logic signed [63:0] opa;
    logic signed [63:0] opb;
    logic               alu_done;
    logic signed [63:0] alu_y;

    ohi_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (opa),
        .b     (opb),
        .done  (alu_done),
        .y     (alu_y)
    );

    // Load fields per axis, and result fields padded to three axes.
    logic signed [63:0] ld_pos [3];
    logic signed [63:0] ld_vel [3];
    logic signed [63:0] ps_full [3];
    logic signed [63:0] vs_full [3];

    assign ld_pos[0] = item.pos_x;
    assign ld_pos[1] = item.pos_y;
    assign ld_pos[2] = item.pos_z;
    assign ld_vel[0] = item.vel_x;
    assign ld_vel[1] = item.vel_y;
    assign ld_vel[2] = item.vel_z;

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        if (a < NUM_AXES)
        begin : g_used
            assign ps_full[a] = ps_reg[a];
            assign vs_full[a] = vs_reg[a];
        end
        else
        begin : g_unused
            assign ps_full[a] = '0;
            assign vs_full[a] = '0;
        end
    end

    // Single read of each store and of the difference row.
    logic [IW-1:0]      t_addr;
    logic [IW-1:0]      dt_idx;
    logic signed [63:0] t_rd;
    logic signed [63:0] dt_rd;
    logic signed [63:0] x_rd;
    logic signed [63:0] v_rd;

    assign t_addr = (state_reg == C_CTI || state_reg == C_ROW) ? i_reg : k_reg;
    assign dt_idx = (state_reg == C_Q || state_reg == C_DT) ? k_reg : i_reg;
    assign t_rd   = times_mem[t_addr];
    assign dt_rd  = dt_reg[dt_idx];
    assign x_rd   = pos_mem[i_reg][ax_reg];
    assign v_rd   = vel_mem[i_reg][ax_reg];

    // Step control: skipped loop indices and completion of a step.
    logic is_arith;
    logic skip;
    logic step_done;
    logic k_last;
    logic j_last;
    logic i_last;
    logic ax_last;
    logic load_xfer;
    logic query_xfer;

    assign k_last     = (k_reg == LAST_PT);
    assign j_last     = (j_reg == LAST_PT);
    assign i_last     = (i_reg == LAST_PT);
    assign ax_last    = (ax_reg == LAST_AX);
    assign load_xfer  = item_valid && item_ready && (item.func == FUNC_LOAD);
    assign query_xfer = item_valid && item_ready && (item.func == FUNC_QUERY);

    always_comb
    begin
        is_arith = state_reg inside {C_DT, C_D, C_R, C_Q, C_S, C_M, C_M2, C_F0,
                                     C_H, C_P, C_PR, C_HD, C_N, C_N2, C_G1,
                                     C_E1, C_E2, C_E, C_G0, C_A1, C_A2, C_A,
                                     C_T1, C_T2, C_PS, C_B1, C_B2, C_B, C_T3,
                                     C_VS};
        case (state_reg)
            C_D, C_H: skip = (k_reg == i_reg);
            C_S:      skip = (j_reg == i_reg);
            C_P:      skip = (k_reg == i_reg) || (k_reg == j_reg);
            default:  skip = 1'b0;
        endcase
        step_done = skip || alu_done;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE: if (query_xfer) state_next = C_CTI;
            C_CTI:  state_next = C_CHK;
            C_CHK:
            begin
                if (k_reg > i_reg && ti_reg == t_rd)
                    state_next = C_OUT;
                else if (k_last)
                    state_next = i_last ? C_DT : C_CTI;
            end
            C_DT:   if (step_done && k_last) state_next = C_ROW;
            C_ROW:  state_next = C_D;
            C_D:
            begin
                if (skip)
                    state_next = k_last ? C_S : C_D;
                else if (alu_done)
                    state_next = C_R;
            end
            C_R:    if (step_done) state_next = C_Q;
            C_Q:    if (step_done) state_next = k_last ? C_S : C_D;
            C_S:    if (step_done && j_last) state_next = C_M;
            C_M:    if (step_done) state_next = C_M2;
            C_M2:   if (step_done) state_next = C_F0;
            C_F0:   if (step_done) state_next = C_H;
            C_H:    if (step_done && k_last) state_next = C_PI;
            C_PI:
            begin
                if (j_reg != i_reg)
                    state_next = C_P;
                else if (j_last)
                    state_next = C_N;
            end
            C_P:    if (step_done && k_last) state_next = C_PR;
            C_PR:   if (step_done) state_next = C_HD;
            C_HD:   if (step_done) state_next = j_last ? C_N : C_PI;
            C_N:    if (step_done) state_next = C_N2;
            C_N2:   if (step_done) state_next = C_G1;
            C_G1:   if (step_done) state_next = C_E1;
            C_E1:   if (step_done) state_next = C_E2;
            C_E2:   if (step_done) state_next = C_E;
            C_E:    if (step_done) state_next = C_G0;
            C_G0:   if (step_done) state_next = C_A1;
            C_A1:   if (step_done) state_next = C_A2;
            C_A2:   if (step_done) state_next = C_A;
            C_A:    if (step_done) state_next = C_T1;
            C_T1:   if (step_done) state_next = C_T2;
            C_T2:   if (step_done) state_next = C_PS;
            C_PS:   if (step_done) state_next = C_B1;
            C_B1:   if (step_done) state_next = C_B2;
            C_B2:   if (step_done) state_next = C_B;
            C_B:    if (step_done) state_next = C_T3;
            C_T3:   if (step_done) state_next = C_VS;
            C_VS:
            begin
                if (step_done)
                begin
                    if (!ax_last)
                        state_next = C_A1;
                    else
                        state_next = i_last ? C_OUT : C_ROW;
                end
            end
            C_OUT:  if (result_ready) state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    // Outputs: handshake, result and operand selection.
    always_comb
    begin
        item_ready       = (state_reg == C_IDLE);
        result_valid     = (state_reg == C_OUT);
        result.status    = coin_reg ? STATUS_COINCIDENT : STATUS_OK;
        result.out_pos_x = coin_reg ? '0 : ps_full[0];
        result.out_pos_y = coin_reg ? '0 : ps_full[1];
        result.out_pos_z = coin_reg ? '0 : ps_full[2];
        result.out_vel_x = coin_reg ? '0 : vs_full[0];
        result.out_vel_y = coin_reg ? '0 : vs_full[1];
        result.out_vel_z = coin_reg ? '0 : vs_full[2];

        alu_req.start = is_arith && !skip && !busy_reg;
        alu_req.op    = OP_ADD;
        opa           = m_reg;
        opb           = m_reg;
        case (state_reg)
            C_DT:
            begin
                alu_req.op = OP_SUB;
                opa        = tq_reg;
                opb        = t_rd;
            end
            C_D:
            begin
                alu_req.op = OP_SUB;
                opa        = ti_reg;
                opb        = t_rd;
            end
            C_R:
            begin
                alu_req.op = OP_DIV;
                opa        = ONE_Q;
                opb        = d_reg;
            end
            C_Q:
            begin
                alu_req.op = OP_DIV;
                opa        = dt_rd;
                opb        = d_reg;
            end
            C_S:
            begin
                opa = s_reg;
                opb = r_reg[j_reg];
            end
            C_M:
            begin
                alu_req.op = OP_MUL;
                opa        = dt_rd;
                opb        = s_reg;
            end
            C_F0:
            begin
                alu_req.op = OP_SUB;
                opa        = ONE_Q;
            end
            C_H:
            begin
                alu_req.op = OP_MUL;
                opa        = h_reg;
                opb        = q_reg[k_reg];
            end
            C_P:
            begin
                alu_req.op = OP_MUL;
                opa        = p_reg;
                opb        = q_reg[k_reg];
            end
            C_PR:
            begin
                alu_req.op = OP_MUL;
                opa        = r_reg[j_reg];
                opb        = p_reg;
            end
            C_HD:
            begin
                opa = hd_reg;
            end
            C_N:
            begin
                alu_req.op = OP_MUL;
                opa        = dt_rd;
                opb        = hd_reg;
            end
            C_G1:
            begin
                opa = h_reg;
            end
            C_E1:
            begin
                alu_req.op = OP_MUL;
                opa        = f0_reg;
                opb        = hd_reg;
            end
            C_E2:
            begin
                alu_req.op = OP_MUL;
                opa        = h_reg;
                opb        = s_reg;
            end
            C_E:
            begin
                alu_req.op = OP_SUB;
                opb        = t2_reg;
            end
            C_A1:
            begin
                alu_req.op = OP_MUL;
                opa        = x_rd;
                opb        = f0_reg;
            end
            C_A2:
            begin
                alu_req.op = OP_MUL;
                opa        = v_rd;
                opb        = dt_rd;
            end
            C_A, C_B:
            begin
                opb = t2_reg;
            end
            C_T1, C_T2, C_T3:
            begin
                alu_req.op = OP_MUL;
                opb        = h_reg;
            end
            C_PS:
            begin
                opa = ps_reg[ax_reg];
            end
            C_B1:
            begin
                alu_req.op = OP_MUL;
                opa        = x_rd;
                opb        = g0_reg;
            end
            C_B2:
            begin
                alu_req.op = OP_MUL;
                opa        = v_rd;
                opb        = g1_reg;
            end
            C_VS:
            begin
                opa = vs_reg[ax_reg];
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            busy_reg  <= 1'b0;
            coin_reg  <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            ax_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (alu_req.start)
                busy_reg <= 1'b1;
            else if (alu_done)
                busy_reg <= 1'b0;

            case (state_reg)
                C_IDLE:
                begin
                    if (query_xfer)
                    begin
                        coin_reg <= 1'b0;
                        i_reg    <= '0;
                        k_reg    <= '0;
                    end
                end
                C_CHK:
                begin
                    if (k_reg > i_reg && ti_reg == t_rd)
                        coin_reg <= 1'b1;
                    else if (k_last)
                    begin
                        k_reg <= '0;
                        i_reg <= i_last ? '0 : i_reg + IDX_ONE;
                    end
                    else
                        k_reg <= k_reg + IDX_ONE;
                end
                C_DT:
                begin
                    if (step_done)
                        k_reg <= k_last ? '0 : k_reg + IDX_ONE;
                end
                C_ROW:
                begin
                    k_reg <= '0;
                end
                C_D:
                begin
                    if (skip)
                    begin
                        k_reg <= k_last ? '0 : k_reg + IDX_ONE;
                        j_reg <= '0;
                    end
                end
                C_Q:
                begin
                    if (step_done)
                    begin
                        k_reg <= k_last ? '0 : k_reg + IDX_ONE;
                        j_reg <= '0;
                    end
                end
                C_S:
                begin
                    if (step_done)
                        j_reg <= j_last ? '0 : j_reg + IDX_ONE;
                end
                C_F0:
                begin
                    k_reg <= '0;
                end
                C_H:
                begin
                    if (step_done)
                    begin
                        k_reg <= k_last ? '0 : k_reg + IDX_ONE;
                        j_reg <= '0;
                    end
                end
                C_PI:
                begin
                    k_reg <= '0;
                    if (j_reg == i_reg && !j_last)
                        j_reg <= j_reg + IDX_ONE;
                end
                C_P:
                begin
                    if (step_done)
                        k_reg <= k_last ? '0 : k_reg + IDX_ONE;
                end
                C_HD:
                begin
                    if (step_done && !j_last)
                        j_reg <= j_reg + IDX_ONE;
                end
                C_G0:
                begin
                    ax_reg <= '0;
                end
                C_VS:
                begin
                    if (step_done)
                    begin
                        if (!ax_last)
                            ax_reg <= ax_reg + AX_ONE;
                        else if (!i_last)
                            i_reg <= i_reg + IDX_ONE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sample store writes.
    always_ff @(posedge clk)
    begin
        if (load_xfer && {{(IW + 2){1'b0}}, item.slot} < (IW + 4)'(NUM_POINTS))
        begin
            times_mem[IW'(item.slot)] <= item.sample_time;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                pos_mem[IW'(item.slot)][a] <= ld_pos[a];
                vel_mem[IW'(item.slot)][a] <= ld_vel[a];
            end
        end
    end

    // Working register writes.
    always_ff @(posedge clk)
    begin
        if (query_xfer)
        begin
            tq_reg <= item.query_time;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                ps_reg[a] <= '0;
                vs_reg[a] <= '0;
            end
        end

        case (state_reg)
            C_CTI, C_ROW: ti_reg <= t_rd;
            C_D:
            begin
                if (skip)
                    s_reg <= '0;
            end
            C_Q:
            begin
                if (alu_done)
                    s_reg <= '0;
            end
            C_PI:         p_reg <= ONE_Q;
            default:
            begin
            end
        endcase

        if (alu_done)
        begin
            case (state_reg)
                C_DT: dt_reg[k_reg] <= alu_y;
                C_D:  d_reg <= alu_y;
                C_R:  r_reg[k_reg] <= alu_y;
                C_Q:  q_reg[k_reg] <= alu_y;
                C_S:  s_reg <= alu_y;
                C_F0:
                begin
                    f0_reg <= alu_y;
                    h_reg  <= ONE_Q;
                end
                C_H:
                begin
                    h_reg  <= alu_y;
                    hd_reg <= '0;
                end
                C_P:  p_reg <= alu_y;
                C_HD: hd_reg <= alu_y;
                C_G1: g1_reg <= alu_y;
                C_G0: g0_reg <= alu_y;
                C_E2, C_A2, C_B2: t2_reg <= alu_y;
                C_PS: ps_reg[ax_reg] <= alu_y;
                C_VS: vs_reg[ax_reg] <= alu_y;
                default: m_reg <= alu_y;
            endcase
        end
        // hd starts at zero even when the row has no other points to multiply.
        if (state_reg == C_H && skip && k_last)
            hd_reg <= '0;
    end

    // Assertions.
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> !result_valid)
        else $error("input accepted while a result is pending");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> busy_reg)
        else $error("arithmetic unit finished without a request");

    a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
        alu_req.start |=> !alu_req.start)
        else $error("second request issued while the unit is busy");

    a_coin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == STATUS_COINCIDENT) |->
        (result.out_pos_x == '0 && result.out_vel_x == '0))
        else $error("coincident-time result carries nonzero vectors");

    a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready) |=> item_ready)
        else $error("block not idle after result transfer");

endmodule
